/* src/lfu_replacement_table_defines.svh */
// assertion macros for the lfu replacement table
`ifndef LFU_REPLACEMENT_TABLE_DEFINES_SVH
`define LFU_REPLACEMENT_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LFU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu table check failed");

// next-cycle implication, checked outside reset
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu table sequence check failed");

`endif

/* src/lfu_pkg.sv */
// shared types and constants for the lfu replacement table
`default_nettype none
package lfu_pkg;
    localparam int CAPACITY   = 16;
    localparam int PAGE_BITS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int ACTION_W   = 3;
    localparam int CFG_W      = 5;
    localparam int OCC_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_ACCESS   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EVICT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_UPD, ST_UPD_END, ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic upd;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic need_upd;
    } t_stat;
endpackage
`default_nettype wire

/* src/lfu_controller.sv */
// sequencing state machine for the lfu replacement table
`default_nettype none
`include "lfu_replacement_table_defines.svh"
module lfu_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               o_valid,
    output lfu_pkg::t_cmd      o_cmd,
    input  wire lfu_pkg::t_stat i_stat
);
    lfu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.addr_last) n_state = lfu_pkg::ST_SCAN_END;
            end
            lfu_pkg::ST_SCAN_END: n_state = lfu_pkg::ST_DECIDE;
            lfu_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_stat.need_upd ? lfu_pkg::ST_UPD : lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_stat.addr_last) n_state = lfu_pkg::ST_UPD_END;
            end
            lfu_pkg::ST_UPD_END: n_state = lfu_pkg::ST_DONE;
            lfu_pkg::ST_DONE: begin
                o_valid = 1'b1;
                n_state = lfu_pkg::ST_IDLE;
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    `LFU_ASSERT_NEXT(a_start_scans, start && !busy, r_state == lfu_pkg::ST_SCAN)
    `LFU_ASSERT_NEXT(a_done_idles, o_valid, !busy)
    `LFU_ASSERT_NEXT(a_scan_end_decides, r_state == lfu_pkg::ST_SCAN_END,
        r_state == lfu_pkg::ST_DECIDE)
endmodule
`default_nettype wire

/* src/lfu_datapath.sv */
// entry storage, scan accumulators and update logic for the lfu table
`default_nettype none
`include "lfu_replacement_table_defines.svh"
module lfu_datapath #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY,
    parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lfu_pkg::t_cmd               i_cmd,
    output lfu_pkg::t_stat                   o_stat,
    input  wire logic [lfu_pkg::ACTION_W-1:0] i_action,
    input  wire logic [PAGE_BITS-1:0]        i_page_id,
    input  wire logic                        i_cfg_we,
    input  wire logic [lfu_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                             o_found,
    output logic                             o_evicted_valid,
    output logic [PAGE_BITS-1:0]             o_evicted_page,
    output logic [lfu_pkg::OCC_W-1:0]        o_occupancy
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {M_NONE, M_HIT, M_DROP, M_MISS} t_mode;

    logic [lfu_pkg::CFG_W-1:0]    r_cap;
    logic [lfu_pkg::ACTION_W-1:0] r_action;
    logic [PAGE_BITS-1:0]         r_page;
    logic [IW-1:0]                r_addr;

    logic [PAGE_BITS-1:0]  mem_page [CAPACITY];
    logic [COUNT_BITS-1:0] mem_cnt  [CAPACITY];
    logic [IW-1:0]         mem_rank [CAPACITY];
    logic [CAPACITY-1:0]   r_valid;
    logic [VW-1:0]         r_vc;

    logic                  r_rd_scan, r_rd_upd, r_rd_v;
    logic [IW-1:0]         r_rd_idx;
    logic [PAGE_BITS-1:0]  r_rd_page;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic [IW-1:0]         r_rd_rank;

    logic                  r_hit, r_vic, r_free;
    logic [IW-1:0]         r_hit_idx, r_hit_rank, r_vic_idx, r_vic_rank, r_free_idx;
    logic [COUNT_BITS-1:0] r_vic_cnt;
    logic [PAGE_BITS-1:0]  r_vic_page;

    t_mode                 r_mode;
    logic [IW-1:0]         r_tgt, r_rr;
    logic                  r_ev_do, r_ins_ok;
    logic                  r_found, r_ev;
    logic [PAGE_BITS-1:0]  r_ev_page;

    t_mode                 d_mode;
    logic [IW-1:0]         d_tgt, d_rr;
    logic                  d_found, d_ev, d_ins_ok, d_full;
    logic [31:0]           eff_cap;

    logic [IW-1:0]         u_rank;
    logic [COUNT_BITS-1:0] u_cnt;
    logic                  u_cnt_we, u_page_we;

    // effective capacity: zero acts as one, clipped to the table size
    always_comb begin
        eff_cap = 32'(r_cap);
        if (eff_cap == 32'd0) eff_cap = 32'd1;
        if (eff_cap > 32'(CAPACITY)) eff_cap = 32'(CAPACITY);
        d_full = 32'(r_vc) >= eff_cap;
    end

    always_comb begin
        d_mode   = M_NONE;
        d_tgt    = r_hit_idx;
        d_rr     = r_hit_rank;
        d_found  = 1'b0;
        d_ev     = 1'b0;
        d_ins_ok = 1'b0;
        unique case (r_action)
            lfu_pkg::ACT_ACCESS: begin
                if (r_hit) begin
                    d_mode  = M_HIT;
                    d_found = 1'b1;
                end else begin
                    d_mode   = M_MISS;
                    d_ev     = d_full && r_vic;
                    d_rr     = r_vic_rank;
                    d_ins_ok = d_ev || r_free;
                    d_tgt    = (d_ev && (!r_free || r_vic_idx < r_free_idx))
                               ? r_vic_idx : r_free_idx;
                end
            end
            lfu_pkg::ACT_REMOVE: begin
                if (r_hit) begin
                    d_mode  = M_DROP;
                    d_found = 1'b1;
                end
            end
            lfu_pkg::ACT_CONTAINS: d_found = r_hit;
            lfu_pkg::ACT_EVICT: begin
                if (r_vic) begin
                    d_mode = M_DROP;
                    d_ev   = 1'b1;
                    d_tgt  = r_vic_idx;
                    d_rr   = r_vic_rank;
                end
            end
            default: d_mode = M_NONE;
        endcase
    end

    assign o_stat.addr_last = (r_addr == IW'(CAPACITY - 1));
    assign o_stat.need_upd  = (d_mode != M_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= lfu_pkg::CFG_RESET;
            r_valid   <= '0;
            r_vc      <= '0;
            r_rd_scan <= 1'b0;
            r_rd_upd  <= 1'b0;
            r_mode    <= M_NONE;
            r_found   <= 1'b0;
            r_ev      <= 1'b0;
            r_ev_page <= '0;
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_vic     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_rd_scan <= i_cmd.scan;
            r_rd_upd  <= i_cmd.upd;
            if (i_cmd.load || i_cmd.decide) begin
                r_addr <= '0;
            end else if (i_cmd.scan || i_cmd.upd) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_vic  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_scan) begin
                if (r_rd_v) begin
                    if (!r_hit && r_rd_page == r_page) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_rank <= r_rd_rank;
                    end
                    if (!r_vic || r_rd_cnt < r_vic_cnt ||
                        (r_rd_cnt == r_vic_cnt && r_rd_rank > r_vic_rank)) begin
                        r_vic      <= 1'b1;
                        r_vic_idx  <= r_rd_idx;
                        r_vic_cnt  <= r_rd_cnt;
                        r_vic_rank <= r_rd_rank;
                        r_vic_page <= r_rd_page;
                    end
                end else if (!r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            if (i_cmd.decide) begin
                r_mode    <= d_mode;
                r_tgt     <= d_tgt;
                r_rr      <= d_rr;
                r_ev_do   <= d_ev;
                r_ins_ok  <= d_ins_ok;
                r_found   <= d_found;
                r_ev      <= d_ev;
                r_ev_page <= d_ev ? r_vic_page : '0;
                if (r_action == lfu_pkg::ACT_CLEAR) begin
                    r_valid <= '0;
                    r_vc    <= '0;
                end else if (d_mode == M_DROP) begin
                    r_valid[d_tgt] <= 1'b0;
                    r_vc           <= r_vc - 1'b1;
                end else if (d_mode == M_MISS) begin
                    // victim slot freed, then the new page placed
                    r_valid <= (r_valid & ~(CAPACITY'(d_ev) << r_vic_idx)) |
                               (CAPACITY'(d_ins_ok) << d_tgt);
                    r_vc <= r_vc - VW'(d_ev) + VW'(d_ins_ok);
                end
            end
        end
    end

    // registered read of the entry under the sweep address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_page   <= i_page_id;
        end
        r_rd_idx  <= r_addr;
        r_rd_v    <= r_valid[r_addr];
        r_rd_page <= mem_page[r_addr];
        r_rd_cnt  <= mem_cnt[r_addr];
        r_rd_rank <= mem_rank[r_addr];
    end

    // per-entry write-back during the update sweep
    always_comb begin
        u_rank    = r_rd_rank;
        u_cnt     = r_rd_cnt;
        u_cnt_we  = 1'b0;
        u_page_we = 1'b0;
        unique case (r_mode)
            M_HIT: begin
                if (r_rd_idx == r_tgt) begin
                    u_rank   = '0;
                    u_cnt    = (&r_rd_cnt) ? r_rd_cnt : r_rd_cnt + 1'b1;
                    u_cnt_we = 1'b1;
                end else if (r_rd_v && r_rd_rank < r_rr) begin
                    u_rank = r_rd_rank + 1'b1;
                end
            end
            M_DROP: if (r_rd_v && r_rd_rank > r_rr) u_rank = r_rd_rank - 1'b1;
            M_MISS: begin
                if (r_ins_ok && r_rd_idx == r_tgt) begin
                    u_rank    = '0;
                    u_cnt     = COUNT_BITS'(1);
                    u_cnt_we  = 1'b1;
                    u_page_we = 1'b1;
                end else if (r_rd_v) begin
                    u_rank = r_rd_rank - IW'(r_ev_do && r_rd_rank > r_rr) + 1'b1;
                end
            end
            default: u_rank = r_rd_rank;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_upd) begin
            mem_rank[r_rd_idx] <= u_rank;
            if (u_cnt_we) mem_cnt[r_rd_idx] <= u_cnt;
            if (u_page_we) mem_page[r_rd_idx] <= r_page;
        end
    end

    assign o_found         = r_found;
    assign o_evicted_valid = r_ev;
    assign o_evicted_page  = r_ev_page;
    assign o_occupancy     = lfu_pkg::OCC_W'(r_vc);

    `LFU_ASSERT_NOW(a_occ_bound, 1'b1, 32'(r_vc) <= 32'(CAPACITY))
    `LFU_ASSERT_NOW(a_no_evict_zero_page, !r_ev, r_ev_page == '0)
    `LFU_ASSERT_NOW(a_hit_never_evicts, r_found, !r_ev)
endmodule
`default_nettype wire

/* src/lfu_replacement_table.sv */
// top level of the lfu replacement table with lru tie-break
// each word runs a scan sweep and a decide step, then an update sweep when entries change;
// lookups, clear and no-ops skip the update sweep and go straight to the result strobe
// the sweeps take one entry per cycle, and a new word is taken only once the last result is out
// and the sequencer is back in idle; the receiver cannot stall
// reset: synchronous active low, table empty, capacity_in_use back to 16
`default_nettype none
module lfu_replacement_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY,
    parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // command side: word taken when start is high and busy is low
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [lfu_pkg::ACTION_W-1:0] i_action,
    input  wire logic [PAGE_BITS-1:0]         i_page_id,
    // capacity_in_use register write
    input  wire logic                         i_cfg_we,
    input  wire logic [lfu_pkg::CFG_W-1:0]    i_cfg_wdata,
    // result word, valid for exactly one cycle
    output logic                              o_valid,
    output logic                              o_found,
    output logic                              o_evicted_valid,
    output logic [PAGE_BITS-1:0]              o_evicted_page,
    output logic [lfu_pkg::OCC_W-1:0]         o_occupancy
);
    // command and status between sequencer and datapath
    lfu_pkg::t_cmd  cmd;
    lfu_pkg::t_stat stat;

    // sequencer: idle, scan sweep, decide, optional update sweep, result strobe
    lfu_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // entry memory, match and victim search, rank and count write-back
    lfu_datapath #(
        .CAPACITY   (CAPACITY),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_page_id       (i_page_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_found         (o_found),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_occupancy     (o_occupancy)
    );
endmodule
`default_nettype wire
